/* hdl/bole_pkg.sv */
// Package for the bounded ordered list engine.
// Holds the sequencer state type, action codes, field widths and the item/result structs.
// No dependencies.
package bole_pkg;

    localparam int VALUE_W = 32;
    localparam int ACTION_W = 2;
    localparam int POS_W = 7;
    localparam int CNT_W = 7;
    localparam int CAP_W = 7;

    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_INDEX  = 2'd2;

    localparam logic [POS_W-1:0] POS_NONE = {POS_W{1'b1}};
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } bole_state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
    } bole_item_t;

    typedef struct packed {
        logic             accepted;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
    } bole_result_t;

endpackage

/* hdl/bole_ram.sv */
// Single-port-write, single-port-read entry store with registered read data.
// Generic; no package dependencies.
module bole_ram #(
    parameter int DEPTH = 64,
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* hdl/bole_ctrl.sv */
// Sequencer for the list engine: scans the entry store through one equality comparator
// and closes gaps one entry at a time. Depends on bole_pkg and bole_ram.
module bole_ctrl
    import bole_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  bole_item_t   in_item,
    input  logic [CAP_W-1:0] capacity,
    input  logic         out_free,
    output logic         res_valid,
    output bole_result_t res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    bole_state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [ACTION_W-1:0] action_reg, action_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic ok_reg, ok_next;
    logic hit_reg, hit_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [VALUE_W-1:0] rd_data;

    logic [CW-1:0] idx_plus;
    logic          at_end;
    logic          match;
    logic [LW-1:0] limit;
    logic          room;
    logic [LW-1:0] pos_ext;
    logic [LW-1:0] cnt_ext;

    bole_ram #(
        .DEPTH(DEPTH),
        .AW(AW),
        .DW(VALUE_W)
    ) u_ram (
        .aclk(aclk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign idx_plus = idx_reg + CW'(1);
    assign at_end   = (idx_plus >= count_reg);
    assign match    = (rd_data == value_reg);
    assign limit    = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);
    assign room     = (LW'(count_reg) < limit);
    assign in_ready = (state_reg == ST_IDLE);

    assign pos_ext = LW'(pos_reg);
    assign cnt_ext = LW'(count_reg);
    assign res.accepted = ok_reg;
    assign res.position = hit_reg ? pos_ext[POS_W-1:0] : POS_NONE;
    assign res.count    = cnt_ext[CNT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        action_reg <= action_next;
        value_reg  <= value_next;
        ok_reg     <= ok_next;
        hit_reg    <= hit_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    case (in_item.action)
                        ACT_APPEND: state_next = ST_DONE;
                        ACT_REMOVE,
                        ACT_INDEX: state_next = (count_reg == '0) ? ST_DONE : ST_SCAN_RD;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_CMP;
            ST_SCAN_CMP: begin
                if (match) begin
                    state_next = (action_reg == ACT_REMOVE) ? ST_SHIFT_RD : ST_DONE;
                end else if (at_end) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SHIFT_RD: state_next = at_end ? ST_DONE : ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = ST_SHIFT_RD;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        idx_next    = idx_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        action_next = action_reg;
        value_next  = value_reg;
        ok_next     = ok_reg;
        hit_next    = hit_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rd_data;
        rd_addr     = idx_reg[AW-1:0];
        res_valid   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    action_next = in_item.action;
                    value_next  = in_item.value;
                    idx_next    = '0;
                    ok_next     = 1'b0;
                    hit_next    = 1'b0;
                    if ((in_item.action == ACT_APPEND) && room) begin
                        wr_en      = 1'b1;
                        wr_addr    = count_reg[AW-1:0];
                        wr_data    = in_item.value;
                        pos_next   = count_reg;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                        hit_next   = 1'b1;
                    end
                end
            end
            ST_SCAN_CMP: begin
                if (match) begin
                    pos_next = idx_reg;
                    ok_next  = 1'b1;
                    hit_next = 1'b1;
                end else begin
                    idx_next = idx_plus;
                end
            end
            ST_SHIFT_RD: begin
                if (at_end) begin
                    count_next = count_reg - CW'(1);
                end else begin
                    rd_addr = idx_plus[AW-1:0];
                end
            end
            ST_SHIFT_WR: begin
                wr_en    = 1'b1;
                idx_next = idx_plus;
            end
            ST_DONE: begin
                res_valid = out_free;
            end
            default: begin
                res_valid = 1'b0;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_SHIFT_WR) || ((state_reg == ST_IDLE) && in_valid))
        else $error("store written outside append or shift");

    a_idx_in_list: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN_RD) || (state_reg == ST_SCAN_CMP) ||
         (state_reg == ST_SHIFT_RD) || (state_reg == ST_SHIFT_WR)) |-> (idx_reg < count_reg))
        else $error("scan index past list end");

    a_append_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_IDLE) && in_valid && (in_item.action == ACT_APPEND) && room)
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not grow the list");

endmodule

/* hdl/bounded_ordered_list_engine_top.sv */
// Top level of the bounded ordered list engine: stream ports, APB capacity register
// and the result output register. Depends on bole_pkg and bole_ctrl.
//
// Keeps up to DEPTH signed 32-bit values in append order in an internal RAM with
// registered reads. One beat is taken at a time. An append, an unused action or an
// action on an empty list goes straight to the result state. Index and remove
// scan the list through one shared comparator, one entry examined at a time (RAM
// read, then compare); a remove then closes the gap one entry at a time
// (read, write back one place lower), then drops the count. The result sits in an
// output register, so the next beat is taken while it waits.
// Capacity lies at byte address 0 and resets to 64; the limit is capacity or DEPTH,
// whichever is smaller. No clearing pass is needed after reset.
module bounded_ordered_list_engine_top
    import bole_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] action, [33:2] value, [39:34] zero
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [7:1] position, [14:8] count, [15] zero
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_W-1:0] capacity_reg, capacity_next;
    logic             m_tvalid_reg, m_tvalid_next;
    bole_result_t     res_data_reg, res_data_next;

    bole_item_t   in_item;
    bole_result_t res;
    logic         res_valid;
    logic         out_free;
    logic         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    assign in_item.action = s_tdata[1:0];
    assign in_item.value  = s_tdata[33:2];

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, res_data_reg.count, res_data_reg.position, res_data_reg.accepted};

    bole_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_item(in_item),
        .capacity(capacity_reg),
        .out_free(out_free),
        .res_valid(res_valid),
        .res(res)
    );

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_write && (paddr[2] == REG_CAPACITY)) begin
            capacity_next = pwdata[CAP_W-1:0];
        end
        m_tvalid_next = m_tvalid_reg;
        res_data_next = res_data_reg;
        if (res_valid) begin
            m_tvalid_next = 1'b1;
            res_data_next = res;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            capacity_reg <= capacity_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        res_data_reg <= res_data_next;
    end

endmodule
